// File: hdl/lesf_pkg.sv
`default_nettype none

package lesf_pkg;

  // width of sizes, counters and the register write data
  localparam int unsigned CW = 11;
  // width of the configuration register index
  localparam int unsigned CFG_IW = 3;
  // entries in the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef logic [CW-1:0] size_t;
  typedef logic [7:0]    char_t;
  typedef logic [CFG_IW-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_GRID_ROWS       = 3'd0;
  localparam cfg_idx_t CFG_GRID_COLUMNS    = 3'd1;
  localparam cfg_idx_t CFG_EMPTY_SYMBOL    = 3'd2;
  localparam cfg_idx_t CFG_OBSTACLE_SYMBOL = 3'd3;
  localparam cfg_idx_t CFG_FULL_SYMBOL     = 3'd4;

  // register values after reset
  localparam size_t GRID_ROWS_RST       = 11'd1;
  localparam size_t GRID_COLUMNS_RST    = 11'd1;
  localparam char_t EMPTY_SYMBOL_RST    = 8'd46;
  localparam char_t OBSTACLE_SYMBOL_RST = 8'd111;
  localparam char_t FULL_SYMBOL_RST     = 8'd120;

  // largest representable size, sizes saturate here
  localparam size_t SIZE_SAT = '1;

  // one classified cell, front to back
  typedef struct packed {
    size_t col;
    size_t row;
    logic  blocked;
    logic  bad;
    logic  done;
  } lesf_item_t;

endpackage

`default_nettype wire

// File: hdl/largest_empty_square_finder.sv
// path: an accepted cell passes through the queue, the back-end stage and the result register
// throughput: one cell per cycle while the output is not stalled, set by the min-and-increment
//   against the left neighbor and one line store access per cell
// reset: asynchronous, active low; registers take their default values,
//   counters and best clear; the line store is not cleared, a fill count marks
//   the entries written since reset and unwritten entries read as zero
`default_nettype none

module largest_empty_square_finder import lesf_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire char_t     cell_char_i,
  input  wire logic      cfg_we_i,
  input  wire cfg_idx_t  cfg_index_i,
  input  wire size_t     cfg_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output size_t          cell_square_o,
  output size_t          best_size_o,
  output size_t          best_row_o,
  output size_t          best_column_o,
  output logic           bad_symbol_o,
  output logic           grid_done_o
);

  lesf_item_t front_item, head_item;
  logic       accept, q_full, q_valid, q_pop;

  assign accept     = in_valid_i && !q_full;
  assign in_stall_o = q_full;

  // classify and place each cell
  lesf_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cell_char_i (cell_char_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_o      (front_item)
  );

  // decoupling queue
  lesf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (front_item),
    .pop_i       (q_pop),
    .head_o      (head_item),
    .valid_o     (q_valid),
    .full_o      (q_full)
  );

  // square sizes and best tracking
  lesf_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (head_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_square_o (cell_square_o),
    .best_size_o   (best_size_o),
    .best_row_o    (best_row_o),
    .best_column_o (best_column_o),
    .bad_symbol_o  (bad_symbol_o),
    .grid_done_o   (grid_done_o)
  );

  // best already includes the current cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_size_o >= cell_square_o))
    else $error("best size below current cell size");

  // no square found means no location
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && best_size_o == '0) |-> (best_row_o == '0 && best_column_o == '0))
    else $error("location set without a best square");

  // unknown characters are open cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_symbol_o) |-> (cell_square_o != '0))
    else $error("unknown character treated as blocked");

endmodule

`default_nettype wire

// File: hdl/lesf_ram.sv
`default_nettype none

module lesf_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port, read returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/lesf_front.sv
`default_nettype none

module lesf_front import lesf_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire char_t      cell_char_i,
  input  wire logic       cfg_we_i,
  input  wire cfg_idx_t   cfg_index_i,
  input  wire size_t      cfg_data_i,
  output lesf_item_t      item_o
);

  size_t grid_rows_q, grid_columns_q;
  char_t empty_q, obstacle_q, full_q;
  size_t col_q, col_d, row_q, row_d;
  size_t rows_lim, cols_lim;
  logic  blocked, bad, row_end, done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q    <= GRID_ROWS_RST;
      grid_columns_q <= GRID_COLUMNS_RST;
      empty_q        <= EMPTY_SYMBOL_RST;
      obstacle_q     <= OBSTACLE_SYMBOL_RST;
      full_q         <= FULL_SYMBOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_ROWS:       grid_rows_q    <= cfg_data_i;
        CFG_GRID_COLUMNS:    grid_columns_q <= cfg_data_i;
        CFG_EMPTY_SYMBOL:    empty_q        <= cfg_data_i[7:0];
        CFG_OBSTACLE_SYMBOL: obstacle_q     <= cfg_data_i[7:0];
        CFG_FULL_SYMBOL:     full_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective grid size: zero acts as one, columns clipped to the line store, rows to MAX_ROWS
  always_comb begin
    if (grid_columns_q == '0) begin
      cols_lim = CW'(1);
    end else if (32'(grid_columns_q) > 32'(MAX_COLUMNS)) begin
      cols_lim = CW'(MAX_COLUMNS);
    end else begin
      cols_lim = grid_columns_q;
    end
    if (grid_rows_q == '0) begin
      rows_lim = CW'(1);
    end else if (32'(grid_rows_q) > 32'(MAX_ROWS)) begin
      rows_lim = CW'(MAX_ROWS);
    end else begin
      rows_lim = grid_rows_q;
    end
  end

  // classify the character, obstacle match wins
  assign blocked = (cell_char_i == obstacle_q);
  assign bad     = !blocked && (cell_char_i != empty_q) && (cell_char_i != full_q);

  // position of this cell within the grid
  assign row_end = ({1'b0, col_q} + (CW+1)'(1)) >= {1'b0, cols_lim};
  assign done    = row_end && (({1'b0, row_q} + (CW+1)'(1)) >= {1'b0, rows_lim});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (done) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign item_o = '{col: col_q, row: row_q, blocked: blocked, bad: bad, done: done};

endmodule

`default_nettype wire

// File: hdl/lesf_queue.sv
`default_nettype none

module lesf_queue import lesf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire lesf_item_t push_item_i,
  input  wire logic       pop_i,
  output lesf_item_t      head_o,
  output logic            valid_o,
  output logic            full_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  lesf_item_t     mem_q [QDEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]  count_q;
  logic           do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == NW'(QDEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/lesf_back.sv
`default_nettype none

module lesf_back import lesf_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire lesf_item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output size_t           cell_square_o,
  output size_t           best_size_o,
  output size_t           best_row_o,
  output size_t           best_column_o,
  output logic            bad_symbol_o,
  output logic            grid_done_o
);

  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  function automatic logic [AW-1:0] idx_of(size_t col);
    if (32'(col) < 32'(MAX_COLUMNS)) begin
      return AW'(col);
    end
    return AW'(MAX_COLUMNS - 1);
  endfunction

  lesf_item_t    b_item_q;
  logic          b_valid_q;
  logic          rd_valid_q, fwd_hit_q;
  size_t         fwd_data_q, ram_rdata;
  size_t         left_q, diag_q;
  size_t         best_size_q, best_row_q, best_col_q;
  size_t         best_size_d, best_row_d, best_col_d;
  logic [AW:0]   fill_q;
  logic [AW-1:0] head_idx, b_idx;
  logic          advance, commit, first_row, first_col;
  size_t         top, diag, left, min_lt, min_all, size;

  // the whole back end moves when the result register can take a result
  assign advance = !out_valid_o || !out_stall_i;
  assign q_pop_o = advance && q_valid_i;
  assign commit  = advance && b_valid_q;

  assign head_idx = idx_of(q_item_i.col);
  assign b_idx    = idx_of(b_item_q.col);

  // line store of the previous row's sizes
  lesf_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_COLUMNS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (b_idx),
    .wdata_i (size),
    .re_i    (q_pop_o),
    .raddr_i (head_idx),
    .rdata_o (ram_rdata)
  );

  // neighbors, outside the grid counts as zero
  assign first_row = (b_item_q.row == '0);
  assign first_col = (b_item_q.col == '0);

  always_comb begin
    if (first_row) begin
      top = '0;
    end else if (fwd_hit_q) begin
      top = fwd_data_q;
    end else if (rd_valid_q) begin
      top = ram_rdata;
    end else begin
      top = '0;
    end
  end

  assign diag = (first_row || first_col) ? '0 : diag_q;
  assign left = first_col ? '0 : left_q;

  // min of three plus one, saturating; zero for a blocked cell
  assign min_lt  = (top < left) ? top : left;
  assign min_all = (diag < min_lt) ? diag : min_lt;
  assign size    = b_item_q.blocked ? '0 :
                   (min_all == SIZE_SAT) ? SIZE_SAT : min_all + CW'(1);

  // best so far, strictly larger replaces
  always_comb begin
    best_size_d = best_size_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    if (size > best_size_q) begin
      best_size_d = size;
      best_row_d  = b_item_q.row + CW'(1);
      best_col_d  = b_item_q.col + CW'(1);
    end
  end

  // stage holding the cell whose line store read is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_item_q   <= q_item_i;
      rd_valid_q <= ({1'b0, head_idx} < fill_q);
      fwd_hit_q  <= commit && (head_idx == b_idx);
      fwd_data_q <= size;
    end
  end

  // running state, cleared at the end of a grid except the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      fill_q      <= '0;
    end else if (commit) begin
      if ({1'b0, b_idx} >= fill_q) begin
        fill_q <= {1'b0, b_idx} + (AW+1)'(1);
      end
      if (b_item_q.done) begin
        left_q      <= '0;
        diag_q      <= '0;
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        left_q      <= size;
        diag_q      <= top;
        best_size_q <= best_size_d;
        best_row_q  <= best_row_d;
        best_col_q  <= best_col_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      cell_square_o <= size;
      best_size_o   <= best_size_d;
      best_row_o    <= best_row_d;
      best_column_o <= best_col_d;
      bad_symbol_o  <= b_item_q.bad;
      grid_done_o   <= b_item_q.done;
    end
  end

endmodule

`default_nettype wire
